### rtl/linear_interp_stereo_resampler_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stereo resampler
// Shared helpers so that every assertion is clocked and reset the same way.
// ----------------------------------------------------------------------------
`ifndef LINEAR_INTERP_STEREO_RESAMPLER_MACROS_SVH
`define LINEAR_INTERP_STEREO_RESAMPLER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define LISR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define LISR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/lisr_pkg.sv
// ----------------------------------------------------------------------------
// lisr_pkg
// Widths, constants and shared types of the stereo linear-interpolation
// resampler.
// ----------------------------------------------------------------------------
package lisr_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int PHASE_FRAC_BITS = 16;
    localparam int STEP_W          = 20;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = STEP_W;

    // The phase must hold a value below one frame plus the largest step.
    localparam int PHASE_W = ((STEP_W > PHASE_FRAC_BITS) ? STEP_W : PHASE_FRAC_BITS) + 1;
    localparam int PROD_W  = SAMPLE_BITS + PHASE_FRAC_BITS + 2;

    localparam logic [PHASE_W-1:0] PHASE_ONE =
        {{(PHASE_W-1){1'b0}}, 1'b1} << PHASE_FRAC_BITS;
    localparam logic [STEP_W-1:0] MIN_STEP =
        {{(STEP_W-1){1'b0}}, 1'b1} << (PHASE_FRAC_BITS - 4);
    localparam logic [STEP_W-1:0] STEP_RESET =
        {{(STEP_W-1){1'b0}}, 1'b1} << PHASE_FRAC_BITS;

    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MONO_SOURCE = 1'b1;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic [PHASE_FRAC_BITS-1:0]    t_frac;

    typedef struct packed {
        t_sample in_left;
        t_sample in_right;
        logic    end_of_stream;
    } t_in;

    typedef struct packed {
        t_sample out_left;
        t_sample out_right;
        logic    run_last;
        logic    stream_end;
    } t_out;

    // Control that travels with one issued output position.
    typedef struct packed {
        logic valid;
        logic last;
        logic stream_end;
    } t_issue;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } t_state;

endpackage

### rtl/linear_interp_stereo_resampler.sv
// ----------------------------------------------------------------------------
// linear_interp_stereo_resampler
// Stereo sample-rate converter by linear interpolation with a Q16 phase step.
// ----------------------------------------------------------------------------
// Each accepted item is one source frame. The block takes it and then issues
// one output position per cycle from its phase sequencer while the output is
// not stalled, and takes no new item until all positions of that frame are
// issued; the single sequencer stepping the phase sets that pace. Both
// channels are computed in parallel lanes with one multiplier each; a result
// passes the lane product register and then the output register. A stalled
// output holds the whole pipeline. Configuration registers: index 0 is
// phase_step, index 1 is mono_source; other indexes are ignored.
module linear_interp_stereo_resampler
    import lisr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [STEP_W-1:0] r_phase_step;
    logic              r_mono;
    logic              adv;
    t_issue            issue;
    t_sample           a_left, b_left, a_right, b_right;
    t_frac             frac;
    t_sample           y_left, y_right;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= STEP_RESET;
            r_mono       <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PHASE_STEP:  r_phase_step <= i_cfg_data[STEP_W-1:0];
                REG_MONO_SOURCE: r_mono       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    lisr_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_phase_step (r_phase_step),
        .i_mono       (r_mono),
        .i_adv        (adv),
        .o_issue      (issue),
        .o_a_left     (a_left),
        .o_b_left     (b_left),
        .o_a_right    (a_right),
        .o_b_right    (b_right),
        .o_frac       (frac)
    );

    lisr_lane u_lane_left (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_a    (a_left),
        .i_b    (b_left),
        .i_frac (frac),
        .o_y    (y_left)
    );

    lisr_lane u_lane_right (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_a    (a_right),
        .i_b    (b_right),
        .i_frac (frac),
        .o_y    (y_right)
    );

    lisr_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_issue     (issue),
        .i_left      (y_left),
        .i_right     (y_right),
        .i_out_ready (i_out_ready),
        .o_adv       (adv),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

### rtl/lisr_lane.sv
// ----------------------------------------------------------------------------
// lisr_lane
// One channel of the interpolator: registers (b - a) * frac, then adds the
// quotient, truncated toward zero, back onto a.
// ----------------------------------------------------------------------------
module lisr_lane
    import lisr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_en,
    input  t_sample i_a,
    input  t_sample i_b,
    input  t_frac   i_frac,
    output t_sample o_y
);

    localparam logic signed [PROD_W-1:0] ROUND_BIAS =
        {{(PROD_W-PHASE_FRAC_BITS){1'b0}}, {PHASE_FRAC_BITS{1'b1}}};

    logic signed [SAMPLE_BITS:0]     diff;
    logic signed [PHASE_FRAC_BITS:0] frac_s;
    logic signed [PROD_W-1:0]        n_prod;
    logic signed [PROD_W-1:0]        r_prod;
    t_sample                         r_a;
    logic signed [PROD_W-1:0]        biased;
    logic signed [PROD_W-1:0]        quot;

    assign diff   = {i_b[SAMPLE_BITS-1], i_b} - {i_a[SAMPLE_BITS-1], i_a};
    assign frac_s = {1'b0, i_frac};
    assign n_prod = diff * frac_s;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_a    <= i_a;
        end
    end

    // A negative product is biased by one frame less one so that the shift
    // truncates toward zero instead of toward minus infinity.
    assign biased = r_prod + (r_prod[PROD_W-1] ? ROUND_BIAS : '0);
    assign quot   = biased >>> PHASE_FRAC_BITS;
    assign o_y    = r_a + quot[SAMPLE_BITS-1:0];

endmodule

### rtl/lisr_merge.sv
// ----------------------------------------------------------------------------
// lisr_merge
// Joins the left and right lanes with the item flags into the output
// register and drives the pipeline advance.
// ----------------------------------------------------------------------------
module lisr_merge
    import lisr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_issue  i_issue,
    input  t_sample i_left,
    input  t_sample i_right,
    input  logic    i_out_ready,
    output logic    o_adv,
    output logic    o_out_valid,
    output t_out    o_out_data
);

    logic r_v1;
    logic r_last1;
    logic r_end1;
    logic r_out_valid;
    t_out r_out;

    // The whole pipe moves only when the output register is free or emptying.
    assign o_adv = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (o_adv) begin
            r_v1        <= i_issue.valid;
            r_out_valid <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_last1 <= i_issue.last;
            r_end1  <= i_issue.stream_end;
            if (r_v1) begin
                r_out.out_left   <= i_left;
                r_out.out_right  <= i_right;
                r_out.run_last   <= r_last1;
                r_out.stream_end <= r_end1;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### rtl/lisr_seq.sv
// ----------------------------------------------------------------------------
// lisr_seq
// Phase sequencer: takes one source frame, walks the output positions that
// fall before it and issues one position per advance to both lanes.
// ----------------------------------------------------------------------------
module lisr_seq
    import lisr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in                i_in_data,
    input  logic [STEP_W-1:0]  i_phase_step,
    input  logic               i_mono,
    input  logic               i_adv,
    output t_issue             o_issue,
    output t_sample            o_a_left,
    output t_sample            o_b_left,
    output t_sample            o_a_right,
    output t_sample            o_b_right,
    output t_frac              o_frac
);

    t_state               r_state, n_state;
    t_sample              r_prev_l, n_prev_l;
    t_sample              r_prev_r, n_prev_r;
    t_sample              r_cur_l, n_cur_l;
    t_sample              r_cur_r, n_cur_r;
    logic                 r_eos, n_eos;
    logic [PHASE_W-1:0]   r_phase, n_phase;
    logic                 r_have_prev, n_have_prev;

    logic [STEP_W-1:0]    step;
    logic [PHASE_W-1:0]   phase_sum;
    logic                 wrap;
    logic                 accept;
    logic                 in_window;
    t_sample              in_right_sel;

    assign step      = (i_phase_step < MIN_STEP) ? MIN_STEP : i_phase_step;
    assign phase_sum = r_phase + {{(PHASE_W-STEP_W){1'b0}}, step};
    assign wrap      = phase_sum >= PHASE_ONE;
    assign accept    = i_in_valid && o_in_ready;
    assign in_window = r_have_prev && (r_phase < PHASE_ONE);
    assign in_right_sel = i_mono ? i_in_data.in_left : i_in_data.in_right;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (in_window) begin
                        n_state = ST_RUN;
                    end else if (i_in_data.end_of_stream) begin
                        n_state = ST_HOLD;
                    end
                end
            end
            ST_RUN: begin
                if (i_adv && wrap) begin
                    n_state = r_eos ? ST_HOLD : ST_IDLE;
                end
            end
            ST_HOLD: begin
                if (i_adv) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_issue     = '0;
        o_a_left    = r_prev_l;
        o_b_left    = r_cur_l;
        o_a_right   = r_prev_r;
        o_b_right   = r_cur_r;
        o_frac      = r_phase[PHASE_FRAC_BITS-1:0];
        n_prev_l    = r_prev_l;
        n_prev_r    = r_prev_r;
        n_cur_l     = r_cur_l;
        n_cur_r     = r_cur_r;
        n_eos       = r_eos;
        n_phase     = r_phase;
        n_have_prev = r_have_prev;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (accept) begin
                    n_cur_l = i_in_data.in_left;
                    n_cur_r = in_right_sel;
                    n_eos   = i_in_data.end_of_stream;
                    // Downsampling may step over a whole frame without output.
                    if (r_have_prev && !in_window) begin
                        n_phase = r_phase - PHASE_ONE;
                    end
                    if (!in_window && !i_in_data.end_of_stream) begin
                        n_prev_l    = i_in_data.in_left;
                        n_prev_r    = in_right_sel;
                        n_have_prev = 1'b1;
                    end
                end
            end
            ST_RUN: begin
                o_issue.valid = 1'b1;
                o_issue.last  = wrap && !r_eos;
                if (i_adv) begin
                    n_phase = wrap ? (phase_sum - PHASE_ONE) : phase_sum;
                    if (wrap && !r_eos) begin
                        n_prev_l    = r_cur_l;
                        n_prev_r    = r_cur_r;
                        n_have_prev = 1'b1;
                    end
                end
            end
            ST_HOLD: begin
                // The held frame goes through the lanes with a zero fraction.
                o_issue.valid      = 1'b1;
                o_issue.last       = 1'b1;
                o_issue.stream_end = 1'b1;
                o_a_left           = r_cur_l;
                o_a_right          = r_cur_r;
                o_frac             = '0;
                if (i_adv) begin
                    n_phase     = '0;
                    n_have_prev = 1'b0;
                    n_prev_l    = '0;
                    n_prev_r    = '0;
                end
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= '0;
            r_have_prev <= 1'b0;
            r_prev_l    <= '0;
            r_prev_r    <= '0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_have_prev <= n_have_prev;
            r_prev_l    <= n_prev_l;
            r_prev_r    <= n_prev_r;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_l <= n_cur_l;
        r_cur_r <= n_cur_r;
        r_eos   <= n_eos;
    end

endmodule

### rtl/lisr_checker.sv
// ----------------------------------------------------------------------------
// lisr_checker
// Port-level checks of the resampler, bound to the top level.
// ----------------------------------------------------------------------------
`include "linear_interp_stereo_resampler_macros.svh"

module lisr_checker
    import lisr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  o_in_ready,
    input  t_in                   i_in_data,
    input  logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  t_out                  o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic in_acc;
    logic out_acc;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    // A waiting result keeps its value until it is taken.
    `LISR_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_out_data), "output item changed while stalled")

    // The held end-of-stream frame always closes its item.
    `LISR_ASSERT_NOW(a_end_is_last, o_out_valid && o_out_data.stream_end,
        o_out_data.run_last, "stream_end item without run_last")

    // An end-of-stream frame always owes a held result, so intake pauses.
    `LISR_ASSERT_NEXT(a_eos_busy, in_acc && i_in_data.end_of_stream,
        !o_in_ready, "input taken again right after an end-of-stream item")

    // Nothing can reach the output without a frame having been taken.
    `LISR_ASSERT_NEXT(a_no_spurious, !o_out_valid && !in_acc && $past(!in_acc) &&
        $past(!in_acc, 2) && $past(!in_acc, 3) && o_in_ready && $past(o_in_ready, 3) &&
        !i_cfg_we && !out_acc, !o_out_valid, "output item appeared without input")

endmodule

bind linear_interp_stereo_resampler lisr_checker u_lisr_checker (.*);

### bench/resampler_checker.sv
// ----------------------------------------------------------------------------
// resampler_checker
// Watches both item channels and the register port of the stereo resampler.
// It predicts the interpolated output frames of every accepted source frame,
// compares each accepted output frame with the oldest prediction, and
// counts mismatches for the testbench top.
// ----------------------------------------------------------------------------
module resampler_checker
    import lisr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in                   i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out                  i_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam longint FRAME_ONE = longint'(1) << PHASE_FRAC_BITS;

    // Register copies, updated from the write port.
    logic [STEP_W-1:0]  step_reg;
    logic               mono_reg;

    // Converter state as the predictor sees it.
    t_sample            prev_left;
    t_sample            prev_right;
    logic [PHASE_W-1:0] phase_acc;
    logic               have_prev;

    t_out               expected_frames[$];
    int                 frame_count;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        frame_count  = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t, output item %0d: %s", $time, frame_count, msg);
        o_fail_count++;
    endtask

    // prev + (cur - prev) * frac / 2^16, truncated toward zero.
    function automatic t_sample interpolate(input t_sample a, input t_sample b,
                                            input logic [PHASE_W-1:0] frac);
        longint diff;
        longint prod;
        diff = longint'(b) - longint'(a);
        prod = diff * longint'(frac);
        return t_sample'(longint'(a) + prod / FRAME_ONE);
    endfunction

    task automatic interpolate_frame(input t_in item);
        t_sample            cur_left;
        t_sample            cur_right;
        logic [PHASE_W-1:0] step;
        t_out               res;
        cur_left  = item.in_left;
        cur_right = mono_reg ? item.in_left : item.in_right;
        step      = (step_reg < MIN_STEP) ? PHASE_W'(MIN_STEP) : PHASE_W'(step_reg);

        if (have_prev) begin
            if (phase_acc >= PHASE_ONE) begin
                // The output position lies beyond this frame, so it is skipped.
                phase_acc = phase_acc - PHASE_ONE;
            end else begin
                while (phase_acc < PHASE_ONE) begin
                    res.out_left   = interpolate(prev_left, cur_left, phase_acc);
                    res.out_right  = interpolate(prev_right, cur_right, phase_acc);
                    res.stream_end = 1'b0;
                    res.run_last   = !item.end_of_stream && (phase_acc + step >= PHASE_ONE);
                    expected_frames.push_back(res);
                    phase_acc = phase_acc + step;
                end
                phase_acc = phase_acc - PHASE_ONE;
            end
        end

        if (item.end_of_stream) begin
            res.out_left   = cur_left;
            res.out_right  = cur_right;
            res.run_last   = 1'b1;
            res.stream_end = 1'b1;
            expected_frames.push_back(res);
            prev_left  = '0;
            prev_right = '0;
            phase_acc  = '0;
            have_prev  = 1'b0;
        end else begin
            prev_left  = cur_left;
            prev_right = cur_right;
            have_prev  = 1'b1;
        end
    endtask

    task automatic compare_frame(input t_out got);
        t_out want;
        if (expected_frames.size() == 0) begin
            report_mismatch($sformatf("unexpected output item L=%0d R=%0d",
                                      got.out_left, got.out_right));
        end else begin
            want = expected_frames.pop_front();
            if (got.out_left !== want.out_left)
                report_mismatch($sformatf("out_left %0d, expected %0d",
                                          got.out_left, want.out_left));
            if (got.out_right !== want.out_right)
                report_mismatch($sformatf("out_right %0d, expected %0d",
                                          got.out_right, want.out_right));
            if (got.run_last !== want.run_last)
                report_mismatch($sformatf("run_last %b, expected %b",
                                          got.run_last, want.run_last));
            if (got.stream_end !== want.stream_end)
                report_mismatch($sformatf("stream_end %b, expected %b",
                                          got.stream_end, want.stream_end));
        end
        frame_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            step_reg   = STEP_RESET;
            mono_reg   = 1'b0;
            prev_left  = '0;
            prev_right = '0;
            phase_acc  = '0;
            have_prev  = 1'b0;
            expected_frames.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_PHASE_STEP:  step_reg = i_cfg_data[STEP_W-1:0];
                    REG_MONO_SOURCE: mono_reg = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready)
                compare_frame(i_out_data);
            if (i_in_valid && i_in_ready)
                interpolate_frame(i_in_data);
        end
        o_pending = expected_frames.size();
    end

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the stereo linear-interpolation resampler.
// A directed run covers sample extremes, end of stream, the first frame, the
// step clamp, mono mode and downsampling skips; random phases then vary the
// step, the mode and the idling of both channels, including one long output
// stall. The checker beside the block predicts and compares every item.
// ----------------------------------------------------------------------------
module testbench;
    import lisr_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 48;
    localparam int LONG_HOLD    = 400;
    localparam int PHASE_ITEMS  = 25;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  in_ready;
    t_in                   in_data     = '0;
    logic                  out_valid;
    logic                  out_ready   = 1'b0;
    t_out                  out_data;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;

    int                    fail_count;
    int                    pending;
    int                    cycle_count = 0;
    int                    send_idle_pct  = 0;
    int                    recv_stall_pct = 0;
    logic                  hold_req    = 1'b0;
    logic                  hold_done   = 1'b0;

    linear_interp_stereo_resampler dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    resampler_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Output side: random stalls, plus one long hold-off when requested.
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic t_sample pick_sample();
        case ($urandom_range(5))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return t_sample'(int'($urandom_range(16)) - 8);
            default: return t_sample'($urandom);
        endcase
    endfunction

    function automatic t_in random_frame();
        t_in item;
        item.in_left       = pick_sample();
        item.in_right      = pick_sample();
        item.end_of_stream = ($urandom_range(11) == 0);
        return item;
    endfunction

    // Offers one item; returns after its accepting edge and any random idle gap.
    task automatic send_frame(input t_sample left, input t_sample right,
                              input logic eos);
        int gap;
        in_valid <= 1'b1;
        in_data  <= '{in_left: left, in_right: right, end_of_stream: eos};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        gap = 0;
        while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Waits until every predicted item is out and the block has gone quiet.
    task automatic settle();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic [STEP_W-1:0] step, input logic mono,
                             input int s_pct, input int r_pct, input logic hold);
        settle();
        write_reg(REG_PHASE_STEP, CFG_DATA_W'(step));
        write_reg(REG_MONO_SOURCE, CFG_DATA_W'(mono));
        send_idle_pct   = s_pct;
        recv_stall_pct <= r_pct;
        hold_req       <= hold;
    endtask

    task automatic random_phase(input logic [STEP_W-1:0] step, input logic mono,
                                input int s_pct, input int r_pct, input logic hold);
        t_in item;
        configure(step, mono, s_pct, r_pct, hold);
        repeat (PHASE_ITEMS) begin
            item = random_frame();
            send_frame(item.in_left, item.in_right, item.end_of_stream);
        end
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Equal rates from reset: first frame, extremes, end of stream, and a
        // first frame that is also the last.
        send_frame(16'sh7FFF, 16'sh8000, 1'b0);
        send_frame(16'sh8000, 16'sh7FFF, 1'b0);
        send_frame(16'sh7FFF, 16'sh8000, 1'b0);
        send_frame(16'sh0000, 16'shFFFF, 1'b1);
        send_frame(16'shFFFF, 16'sh0001, 1'b1);
        send_frame(16'sh5555, 16'shAAAA, 1'b0);
        send_frame(16'shAAAA, 16'sh5555, 1'b1);

        // A zero step is clamped to the minimum: sixteen outputs per item.
        configure('0, 1'b0, 0, 0, 1'b0);
        send_frame(16'sh8000, 16'sh7FFF, 1'b0);
        send_frame(16'sh7FFF, 16'sh8000, 1'b0);
        send_frame(16'sh1234, 16'shEDCC, 1'b1);

        // A step of eight frames in mono mode: most frames are skipped.
        configure(20'd524288, 1'b1, 0, 0, 1'b0);
        send_frame(16'sh7FFF, 16'sh0000, 1'b0);
        send_frame(16'sh8000, 16'sh1234, 1'b0);
        send_frame(16'sh0100, 16'shFF00, 1'b0);
        send_frame(16'sh0003, 16'sh7FFF, 1'b0);
        send_frame(16'shFFFD, 16'sh8000, 1'b0);
        send_frame(16'sh4000, 16'shFFFF, 1'b0);
        send_frame(16'shC000, 16'sh0001, 1'b0);
        send_frame(16'sh0001, 16'shAAAA, 1'b1);

        // Step of one and a half frames: truncation of negative products.
        configure(20'd98304, 1'b0, 0, 0, 1'b0);
        send_frame(16'sh0000, 16'sh0000, 1'b0);
        send_frame(16'shFFFD, 16'sh0003, 1'b0);
        send_frame(16'sh0007, 16'shFFF9, 1'b0);
        send_frame(16'sh8000, 16'sh7FFF, 1'b1);

        random_phase(STEP_W'($urandom_range(4096, 524288)), 1'b0, 0, 0, 1'b0);
        random_phase(STEP_W'($urandom_range(4096, 524288)), 1'($urandom), 47, 0, 1'b0);
        random_phase(20'd4096, 1'b0, 0, 47, 1'b0);
        random_phase(STEP_W'($urandom_range(4096, 524288)), 1'($urandom), 10, 10, 1'b0);
        // The output stalls for a long stretch while items keep coming.
        random_phase(20'd4096, 1'b1, 0, 0, 1'b1);
        random_phase(STEP_W'($urandom_range(4096, 65536)), 1'($urandom), 10, 10, 1'b0);

        recv_stall_pct <= 0;
        settle();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/lisr_pkg.sv
rtl/lisr_lane.sv
rtl/lisr_merge.sv
rtl/lisr_seq.sv
rtl/linear_interp_stereo_resampler.sv
rtl/lisr_checker.sv
bench/resampler_checker.sv
bench/testbench.sv
